// File: hdl/rcfp_pkg.sv
// shared types and constants for the serial frame parser
// no dependencies; imported by rcfp_ctrl, rcfp_dp and rc_serial_frame_parser
package rcfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int CH_IDX_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [VALUE_W-1:0] SUM_INIT = 16'hFFFF;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd32;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 1'b1;

    localparam logic STATUS_CHANNEL = 1'b0;
    localparam logic STATUS_ERROR   = 1'b1;

    typedef enum logic [5:0] {
        ST_HUNT    = 6'b000001,
        ST_FIRST   = 6'b000010,
        ST_BODY    = 6'b000100,
        ST_EMIT_RD = 6'b001000,
        ST_EMIT_WR = 6'b010000,
        ST_ERR     = 6'b100000
    } rcfp_state_t;

    typedef struct packed {
        logic hdr_first;
        logic hdr_second;
        logic hunt;
        logic body;
        logic emit_rd;
        logic out_load_ch;
        logic out_load_err;
    } rcfp_cmd_t;

    typedef struct packed {
        logic is_first;
        logic is_second;
        logic final_byte;
        logic sum_match;
        logic emit_last;
        logic out_free;
    } rcfp_sts_t;

endpackage

// File: hdl/rcfp_ctrl.sv
// frame parser controller: header hunt, body collection and result sequencing
// depends on rcfp_pkg; drives commands into rcfp_dp
module rcfp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rcfp_pkg::rcfp_sts_t  sts,
    output rcfp_pkg::rcfp_cmd_t  cmd
);
    import rcfp_pkg::*;

    rcfp_state_t state_reg;
    rcfp_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT, ST_FIRST: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.is_first) begin
                        cmd.hdr_first = 1'b1;
                        state_next    = ST_FIRST;
                    end else if (state_reg == ST_FIRST && sts.is_second) begin
                        cmd.hdr_second = 1'b1;
                        state_next     = ST_BODY;
                    end else begin
                        cmd.hunt   = 1'b1;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_BODY: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.body = 1'b1;
                    if (sts.final_byte) begin
                        state_next = sts.sum_match ? ST_EMIT_RD : ST_ERR;
                    end
                end
            end
            ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (sts.out_free) begin
                    cmd.out_load_ch = 1'b1;
                    state_next      = sts.emit_last ? ST_HUNT : ST_EMIT_RD;
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.out_load_err = 1'b1;
                    state_next       = ST_HUNT;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

// File: hdl/rcfp_dp.sv
// frame parser datapath: header registers, byte counter, running checksum,
// channel store and result register; depends on rcfp_pkg, commanded by rcfp_ctrl
module rcfp_dp #(
    parameter int CHANNELS    = 14,
    parameter int FRAME_BYTES = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rcfp_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [rcfp_pkg::BYTE_W-1:0]       cfg_wr_data,
    input  logic [rcfp_pkg::BYTE_W-1:0]       s_rx_byte,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic                              m_status,
    output logic [rcfp_pkg::CH_IDX_W-1:0]     m_channel_index,
    output logic [rcfp_pkg::VALUE_W-1:0]      m_channel_value,
    output logic                              m_last,
    input  rcfp_pkg::rcfp_cmd_t               cmd,
    output rcfp_pkg::rcfp_sts_t               sts
);
    import rcfp_pkg::*;

    localparam int CW       = $clog2(FRAME_BYTES);
    localparam int IW       = $clog2(CHANNELS);
    localparam int FRAME_CH = (FRAME_BYTES - 4) / 2;
    localparam int EMIT_CH  = (FRAME_CH < CHANNELS) ? FRAME_CH : CHANNELS;

    logic [BYTE_W-1:0]   header_first_reg;
    logic [BYTE_W-1:0]   header_second_reg;
    logic [CW-1:0]       count_reg;
    logic [VALUE_W-1:0]  sum_reg;
    logic [BYTE_W-1:0]   pending_reg;
    logic [IW-1:0]       emit_idx_reg;
    logic [VALUE_W-1:0]  rd_data_reg;
    logic                m_valid_reg;
    logic                m_status_reg;
    logic [CH_IDX_W-1:0] m_index_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic                m_last_reg;

    logic [VALUE_W-1:0]  store [CHANNELS];

    logic [CW-1:0]       wr_pos;
    logic [CW-1:0]       wr_ch;
    logic                in_payload;
    logic                wr_en;
    logic                take_low;
    logic [VALUE_W-1:0]  sum_sub;

    assign sum_sub    = sum_reg - {8'd0, s_rx_byte};
    assign in_payload = count_reg < CW'(FRAME_BYTES - 2);
    assign wr_pos     = count_reg - CW'(3);
    assign wr_ch      = wr_pos >> 1;
    assign wr_en      = cmd.body && in_payload && count_reg[0] && (int'(wr_ch) < CHANNELS);
    assign take_low   = (in_payload && !count_reg[0]) || (count_reg == CW'(FRAME_BYTES - 2));

    assign sts.is_first   = s_rx_byte == header_first_reg;
    assign sts.is_second  = s_rx_byte == header_second_reg;
    assign sts.final_byte = count_reg == CW'(FRAME_BYTES - 1);
    assign sts.sum_match  = {s_rx_byte, pending_reg} == sum_reg;
    assign sts.emit_last  = emit_idx_reg == IW'(EMIT_CH - 1);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            count_reg         <= '0;
            sum_reg           <= SUM_INIT;
            pending_reg       <= '0;
            emit_idx_reg      <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_HEADER_FIRST:  header_first_reg  <= cfg_wr_data;
                    CFG_HEADER_SECOND: header_second_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.hdr_first) begin
                count_reg <= CW'(1);
                sum_reg   <= SUM_INIT - {8'd0, s_rx_byte};
            end
            if (cmd.hdr_second) begin
                count_reg <= CW'(2);
                sum_reg   <= sum_sub;
            end
            if (cmd.hunt) begin
                count_reg <= '0;
            end
            if (cmd.body) begin
                if (sts.final_byte) begin
                    count_reg    <= '0;
                    sum_reg      <= SUM_INIT;
                    emit_idx_reg <= '0;
                end else begin
                    count_reg <= count_reg + CW'(1);
                    if (in_payload) begin
                        sum_reg <= sum_sub;
                    end
                    if (take_low) begin
                        pending_reg <= s_rx_byte;
                    end
                end
            end
            if (cmd.out_load_ch) begin
                m_valid_reg  <= 1'b1;
                emit_idx_reg <= sts.emit_last ? '0 : emit_idx_reg + IW'(1);
            end else if (cmd.out_load_err) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // channel store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_ch[IW-1:0]] <= {s_rx_byte, pending_reg};
        end
        if (cmd.emit_rd) begin
            rd_data_reg <= store[emit_idx_reg];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load_ch) begin
            m_status_reg <= STATUS_CHANNEL;
            m_index_reg  <= CH_IDX_W'(emit_idx_reg);
            m_value_reg  <= rd_data_reg;
            m_last_reg   <= sts.emit_last;
        end else if (cmd.out_load_err) begin
            m_status_reg <= STATUS_ERROR;
            m_index_reg  <= '0;
            m_value_reg  <= '0;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_channel_index = m_index_reg;
    assign m_channel_value = m_value_reg;
    assign m_last          = m_last_reg;

endmodule

// File: hdl/rc_serial_frame_parser.sv
// serial frame parser top level: header, payload and checksum bytes one per transfer
// s_ready is high while hunting headers and collecting the body; after the final
// checksum byte each of min(CHANNELS,(FRAME_BYTES-4)/2) channel results is read from
// the single read port of the channel store, then loaded once the result register is
// free; s_ready stays low until the last result or the checksum error result is loaded
// reset: aresetn synchronous active low, clears control state, headers to 0x20 and 0x40
module rc_serial_frame_parser #(
    parameter int CHANNELS    = 14,
    parameter int FRAME_BYTES = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rcfp_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [rcfp_pkg::BYTE_W-1:0]       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rcfp_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_status,
    output logic [rcfp_pkg::CH_IDX_W-1:0]     m_channel_index,
    output logic [rcfp_pkg::VALUE_W-1:0]      m_channel_value,
    output logic                              m_last
);
    import rcfp_pkg::*;

    rcfp_cmd_t cmd;
    rcfp_sts_t sts;

    rcfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rcfp_dp #(
        .CHANNELS    (CHANNELS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_rx_byte       (s_rx_byte),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_last          (m_last),
        .cmd             (cmd),
        .sts             (sts)
    );

    // no input transfer while results are being sequenced
    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_rd || cmd.out_load_ch || cmd.out_load_err) |-> !s_ready)
        else $error("input ready during result sequencing");

    // a result is loaded only when the result register is free
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load_ch || cmd.out_load_err) |-> sts.out_free)
        else $error("result register overwritten");

    // an error result is always the last one with zero index and value
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_ERROR) |->
        (m_last && m_channel_index == '0 && m_channel_value == '0))
        else $error("malformed checksum error result");

endmodule
